### rtl/mbsr_pkg.sv
`timescale 1ns / 1ps

package mbsr_pkg;

    // defaults and sizes
    localparam int PORTS_DEF = 4;
    localparam int HEAD_LEN  = 7;

    // operation codes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_PRESET = 1'b1;

    // register index of the bank value
    localparam logic CFG_BANK_VALUE = 1'b0;

    // midi byte codes
    localparam logic [7:0] ST_SYSEX    = 8'hF0;
    localparam logic [7:0] ST_EOX      = 8'hF7;
    localparam logic [7:0] ST_RT_MIN   = 8'hF8;
    localparam logic [7:0] KIND_CC     = 8'hB0;
    localparam logic [7:0] KIND_PC     = 8'hC0;
    localparam logic [7:0] KIND_CP     = 8'hD0;
    localparam logic [7:0] CC_BANK_LSB = 8'h20;
    localparam logic [15:0] ALL_CH     = 16'hFFFF;

    // step of the last beat of a preset run; a leading end-of-exclusive takes step 0
    localparam logic [5:0] PRESET_LAST = 6'd32;

    typedef struct packed {
        logic       op;
        logic [1:0] port;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] msg_len;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_msg;

    typedef enum logic {
        K_MSG,
        K_PRESET
    } t_kind;

    // one job for the result sequencer
    typedef struct packed {
        t_kind      kind;
        logic [3:0] ch;
        t_msg       msg;
        logic       start1;
    } t_job;

    // per-port parser state
    typedef struct packed {
        logic        sysex_on;
        logic [2:0]  count;
        logic [7:0]  rstat;
        logic [1:0]  have;
        logic [1:0]  need;
        logic [7:0]  first;
        logic [15:0] mask;
    } t_pstate;

    typedef logic [HEAD_LEN-1:0][7:0] t_head;

endpackage

### rtl/midi_bank_select_remapper_core.sv
`timescale 1ns / 1ps
// an input beat passes the read-stage register and then the sequencer job register before it leaves
// throughput: one input beat per cycle while each byte yields at most one result and the
//   output is not stalled; a byte with k results (preset run 32, or 33 after F7) holds
//   the pipe until the last leaves; the rate is set by the result sequencer; the per-port
//   state memory is read at accept, written back at consume, the value just written forwarded
// reset: synchronous active low; per-port state reads as zero, bank value zero,
//   the sysex head memory is not cleared

module midi_bank_select_remapper_core #(
    parameter int PORTS = mbsr_pkg::PORTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mbsr_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mbsr_pkg::t_out o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import mbsr_pkg::*;

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam logic [4:0] PORTS_W = 5'(PORTS);

    localparam logic [7:0] ID_NON_RT  = 8'h7E;
    localparam logic [7:0] ID_XG      = 8'h43;
    localparam logic [7:0] ID_GS      = 8'h41;
    localparam logic [7:0] GM_SUB     = 8'h09;
    localparam logic [7:0] GM_ON      = 8'h01;
    localparam logic [7:0] GM2_ON     = 8'h03;
    localparam logic [7:0] XG_MODEL   = 8'h4C;
    localparam logic [7:0] GS_MODEL   = 8'h42;
    localparam logic [7:0] GS_CMD     = 8'h12;
    localparam logic [7:0] GS_ADDR_HI = 8'h40;
    localparam logic [7:0] GS_DATA    = 8'h7F;

    // port number wrapped into the configured port count
    function automatic logic [PW-1:0] port_idx(input logic [1:0] p);
        logic [4:0] v;
        v = {3'd0, p};
        for (int k = 0; k < 3; k++) begin
            if (v >= PORTS_W) v = v - PORTS_W;
        end
        return v[PW-1:0];
    endfunction

    // gm, xg and gs reset patterns over the kept sysex head
    function automatic logic reset_match(input t_head x, input logic [2:0] n);
        logic gm;
        logic xg;
        logic gs;
        gm = (n >= 3'd4) && x[0] == ID_NON_RT && x[2] == GM_SUB &&
             (x[3] == GM_ON || x[3] == GM2_ON);
        xg = (n >= 3'd7) && x[0] == ID_XG && x[2] == XG_MODEL && x[3] == 8'h00 &&
             x[4] == 8'h00 && x[5] == ID_NON_RT;
        gs = (n >= 3'd7) && x[0] == ID_GS && x[2] == GS_MODEL && x[3] == GS_CMD &&
             (x[4] == GS_ADDR_HI || x[4] == 8'h00) && x[5] == 8'h00 && x[6] == GS_DATA;
        return gm || xg || gs;
    endfunction

    // configuration
    logic [6:0] r_bank;

    // state memories
    t_pstate r_st_mem [PORTS];
    t_head   r_head_mem [PORTS];
    logic [PORTS-1:0] r_pvalid;

    // read stage
    logic      r_s1_vld;
    t_in       r_s1;
    logic [PW-1:0] r_s1_idx;
    t_pstate   r_rd_st;
    t_head     r_head_rd;
    logic      r_rd_vld;
    logic      r_hit;
    t_pstate   r_fwd_st;
    t_head     r_fwd_head;

    logic [PW-1:0] in_idx;
    logic      in_accept;
    logic      s1_consume;
    logic      s1_has_job;
    logic      head_we;
    logic      seq_free;
    t_job      job;
    t_pstate   cur;
    t_pstate   n_st;
    t_head     cur_head;
    t_head     n_head;
    logic [7:0] b;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] kind;
    logic [3:0] ch;
    logic [15:0] ch_bit;
    logic      go_on;
    t_msg      one;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_BANK_VALUE) ? {25'd0, r_bank} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 7'd0;
        end else if (psel && penable && pwrite && paddr[2] == CFG_BANK_VALUE) begin
            r_bank <= pwdata[6:0];
        end
    end

    // input handshake
    assign in_idx     = port_idx(i_in.port);
    assign s1_consume = r_s1_vld && (!s1_has_job || seq_free);
    assign o_in_stall = r_s1_vld && !s1_consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    // current state, with the value just written forwarded
    assign cur      = r_hit ? r_fwd_st : (r_rd_vld ? r_rd_st : '0);
    assign cur_head = r_hit ? r_fwd_head : r_head_rd;

    // parser update for the byte in the read stage
    always_comb begin
        b          = r_s1.data_byte;
        one        = '{len: 2'd1, a: b, b: 8'h00, c: 8'h00};
        n_st       = cur;
        n_head     = cur_head;
        head_we    = 1'b0;
        s1_has_job = 1'b0;
        job        = '{kind: K_MSG, ch: 4'd0, msg: one, start1: 1'b1};
        go_on      = 1'b0;
        d0         = b;
        d1         = 8'h00;
        kind       = {cur.rstat[7:4], 4'h0};
        ch         = cur.rstat[3:0];
        ch_bit     = 16'd1 << ch;
        if (r_s1.op == OP_PRESET) begin
            s1_has_job = 1'b1;
            job.kind   = K_PRESET;
            n_st.mask  = ALL_CH;
        end else if (b >= ST_RT_MIN) begin
            s1_has_job = 1'b1;
        end else begin
            go_on = 1'b1;
            if (cur.sysex_on) begin
                if (b == ST_EOX) begin
                    n_st.sysex_on = 1'b0;
                    s1_has_job    = 1'b1;
                    go_on         = 1'b0;
                    if (reset_match(cur_head, cur.count)) begin
                        job.kind   = K_PRESET;
                        job.start1 = 1'b0;
                        n_st.mask  = ALL_CH;
                    end
                end else if (b[7]) begin
                    n_st.sysex_on = 1'b0;
                    n_st.have     = 2'd0;
                end else begin
                    if (cur.count < 3'(HEAD_LEN)) begin
                        head_we              = 1'b1;
                        n_head[cur.count]    = b;
                        n_st.count           = cur.count + 3'd1;
                    end
                    s1_has_job = 1'b1;
                    go_on      = 1'b0;
                end
            end
            if (go_on) begin
                if (b == ST_SYSEX) begin
                    n_st.sysex_on = 1'b1;
                    n_st.count    = 3'd0;
                    n_st.rstat    = 8'h00;
                    s1_has_job    = 1'b1;
                end else if (b[7]) begin
                    if (b >= ST_SYSEX) begin
                        n_st.rstat = 8'h00;
                        s1_has_job = 1'b1;
                    end else begin
                        n_st.rstat = b;
                        n_st.have  = 2'd0;
                        n_st.need  = ({b[7:4], 4'h0} == KIND_PC ||
                                      {b[7:4], 4'h0} == KIND_CP) ? 2'd1 : 2'd2;
                    end
                end else if (cur.rstat != 8'h00) begin
                    if (cur.need == 2'd2 && cur.have == 2'd0) begin
                        n_st.first = b;
                        n_st.have  = 2'd1;
                    end else begin
                        if (cur.need == 2'd2) begin
                            d0 = cur.first;
                            d1 = b;
                        end
                        n_st.have = 2'd0;
                        if (kind == KIND_CC && d0 == CC_BANK_LSB) begin
                            d1        = {1'b0, r_bank};
                            n_st.mask = cur.mask | ch_bit;
                        end else if (kind == KIND_PC && (cur.mask & ch_bit) == 16'd0) begin
                            n_st.mask  = cur.mask | ch_bit;
                            job.start1 = 1'b0;
                        end
                        s1_has_job = 1'b1;
                        job.ch     = ch;
                        job.msg    = '{len: (cur.need == 2'd2) ? 2'd3 : 2'd2,
                                       a: cur.rstat, b: d0, c: d1};
                    end
                end
            end
        end
    end

    // memory read at accept, write back at consume
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_st   <= r_st_mem[in_idx];
            r_head_rd <= r_head_mem[in_idx];
            r_s1      <= i_in;
            r_s1_idx  <= in_idx;
        end
        if (s1_consume) begin
            r_st_mem[r_s1_idx] <= n_st;
            r_fwd_st           <= n_st;
            r_fwd_head         <= n_head;
            if (head_we) begin
                r_head_mem[r_s1_idx][cur.count] <= b;
            end
        end
    end

    // pipeline control and per-port valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_pvalid <= '0;
        end else begin
            if (in_accept) begin
                r_s1_vld <= 1'b1;
                r_rd_vld <= r_pvalid[in_idx];
                r_hit    <= s1_consume && (r_s1_idx == in_idx);
            end else if (s1_consume) begin
                r_s1_vld <= 1'b0;
                r_hit    <= 1'b0;
            end
            if (s1_consume) begin
                r_pvalid[r_s1_idx] <= 1'b1;
            end
        end
    end

    // result sequencer and output register
    mbsr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s1_consume && s1_has_job),
        .i_job       (job),
        .i_bank      (r_bank),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_free      (seq_free)
    );

    // checks
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.msg_len != 2'd0)
        else $error("result beat with zero length");

    a_job_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_consume && s1_has_job |=> o_out_valid)
        else $error("consumed byte produced no result beat");

    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_s1_vld)
        else $error("forwarding active with empty read stage");

    a_preset_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_consume && s1_has_job && job.kind == K_PRESET |-> n_st.mask == ALL_CH)
        else $error("preset run without all channels marked");

endmodule

### rtl/mbsr_seq.sv
`timescale 1ns / 1ps

module mbsr_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  mbsr_pkg::t_job i_job,
    input  logic [6:0]    i_bank,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output mbsr_pkg::t_out o_out,
    output logic          o_free
);
    import mbsr_pkg::*;

    logic       r_vld;
    t_job       r_job;
    logic [5:0] r_step;
    logic [4:0] p;
    logic [3:0] pch;
    logic       is_last;
    logic       beat_ok;
    logic       done;
    t_msg       m;

    // pick the message for the current step
    always_comb begin
        p       = 5'(r_step - 6'd1);
        pch     = p[4:1];
        m       = r_job.msg;
        is_last = 1'b0;
        unique case (r_job.kind)
            K_MSG: begin
                is_last = r_step[0];
                if (!r_step[0]) begin
                    m = '{len: 2'd3, a: KIND_CC | {4'h0, r_job.ch}, b: CC_BANK_LSB,
                          c: {1'b0, i_bank}};
                end
            end
            K_PRESET: begin
                is_last = (r_step == PRESET_LAST);
                if (r_step != 6'd0) begin
                    if (p[0]) begin
                        m = '{len: 2'd2, a: KIND_PC | {4'h0, pch}, b: 8'h00, c: 8'h00};
                    end else begin
                        m = '{len: 2'd3, a: KIND_CC | {4'h0, pch}, b: CC_BANK_LSB,
                              c: {1'b0, i_bank}};
                    end
                end
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    assign beat_ok     = r_vld && !i_out_stall;
    assign done        = beat_ok && is_last;
    assign o_free      = !r_vld || done;
    assign o_out_valid = r_vld;
    assign o_out       = '{msg_len: m.len, byte_a: m.a, byte_b: m.b, byte_c: m.c,
                           last: is_last};

    // job register and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_step <= 6'd0;
        end else if (i_load) begin
            r_vld  <= 1'b1;
            r_job  <= i_job;
            r_step <= {5'd0, i_job.start1};
        end else if (done) begin
            r_vld <= 1'b0;
        end else if (beat_ok) begin
            r_step <= r_step + 6'd1;
        end
    end

endmodule

### verif/midi_bank_select_remapper_core_tb.sv
`timescale 1ns / 1ps

module midi_bank_select_remapper_core_tb;
    import mbsr_pkg::*;

    localparam int NPORTS     = PORTS_DEF;
    localparam int SETTLE     = 8;
    localparam int IDLE_LIMIT = 2000;

    localparam logic [2:0] BANK_ADDR = 3'(4 * int'(CFG_BANK_VALUE));

    // sysex reset signatures
    localparam logic [7:0] UNIV_NRT    = 8'h7E;
    localparam logic [7:0] GM_SUB      = 8'h09;
    localparam logic [7:0] GM_ON       = 8'h01;
    localparam logic [7:0] GM2_ON      = 8'h03;
    localparam logic [7:0] ID_XG       = 8'h43;
    localparam logic [7:0] XG_MODEL    = 8'h4C;
    localparam logic [7:0] XG_ON       = 8'h7E;
    localparam logic [7:0] ID_GS       = 8'h41;
    localparam logic [7:0] GS_MODEL    = 8'h42;
    localparam logic [7:0] GS_DT1      = 8'h12;
    localparam logic [7:0] GS_ADDR_HI  = 8'h40;
    localparam logic [7:0] GS_ADDR_ALT = 8'h00;
    localparam logic [7:0] GS_ON       = 8'h7F;

    // how a directed row gets its expected beats
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_ECHO
    } t_exp;

    typedef struct {
        t_exp chk;
        t_in  item;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in         i_in       = '0;
    logic        i_out_stall = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out;
    logic [31:0] prdata;
    logic        pready;

    // parser state mirror
    t_pstate    port_st   [NPORTS];
    logic [7:0] port_head [NPORTS][HEAD_LEN];
    logic [6:0] bank_reg;
    t_out       burst        [$];
    t_out       pending_msgs [$];
    t_row       dir_rows     [$];

    int   gap_pct      = 0;
    int   stall_pct    = 0;
    int   fail_count   = 0;
    int   beats_in     = 0;
    int   beats_out    = 0;
    int   useful       = 0;
    int   quiet_cycles = 0;
    t_out want;

    midi_bank_select_remapper_core #(.PORTS(NPORTS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void add_msg(logic [1:0] len, logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c);
        t_out m;
        m.msg_len = len;
        m.byte_a  = a;
        m.byte_b  = (len >= 2'd2) ? b : 8'h00;
        m.byte_c  = (len == 2'd3) ? c : 8'h00;
        m.last    = 1'b0;
        burst.push_back(m);
    endfunction

    function automatic void add_bank_select(logic [3:0] ch);
        add_msg(2'd3, {KIND_CC[7:4], ch}, CC_BANK_LSB, {1'b0, bank_reg});
    endfunction

    // bank select and program 0 on every channel
    function automatic void add_preset(int p);
        for (int ch = 0; ch < 16; ch++) begin
            add_bank_select(4'(ch));
            add_msg(2'd2, {KIND_PC[7:4], 4'(ch)}, 8'h00, 8'h00);
        end
        port_st[p].mask = ALL_CH;
    endfunction

    // gm, xg or gs reset in the kept sysex head
    function automatic bit head_is_reset(int p);
        int n;
        n = int'(port_st[p].count);
        if (n >= 4 && port_head[p][0] == UNIV_NRT && port_head[p][2] == GM_SUB &&
            (port_head[p][3] == GM_ON || port_head[p][3] == GM2_ON))
            return 1'b1;
        if (n >= 7 && port_head[p][0] == ID_XG && port_head[p][2] == XG_MODEL &&
            port_head[p][3] == 8'h00 && port_head[p][4] == 8'h00 &&
            port_head[p][5] == XG_ON)
            return 1'b1;
        if (n >= 7 && port_head[p][0] == ID_GS && port_head[p][2] == GS_MODEL &&
            port_head[p][3] == GS_DT1 &&
            (port_head[p][4] == GS_ADDR_HI || port_head[p][4] == GS_ADDR_ALT) &&
            port_head[p][5] == 8'h00 && port_head[p][6] == GS_ON)
            return 1'b1;
        return 1'b0;
    endfunction

    // fills burst with the messages one input beat yields; returns 1 for a dropped orphan
    function automatic bit remap_byte(t_in it);
        int         p;
        logic [7:0] b;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [3:0] ch;
        bit         done;
        bit         ignored;
        p       = int'(it.port) % NPORTS;
        b       = it.data_byte;
        done    = 1'b0;
        ignored = 1'b0;
        burst.delete();
        if (it.op == OP_PRESET) begin
            add_preset(p);
            done = 1'b1;
        end else if (b >= ST_RT_MIN) begin
            add_msg(2'd1, b, 8'h00, 8'h00);
            done = 1'b1;
        end else if (port_st[p].sysex_on) begin
            if (b == ST_EOX) begin
                port_st[p].sysex_on = 1'b0;
                add_msg(2'd1, b, 8'h00, 8'h00);
                if (head_is_reset(p))
                    add_preset(p);
                done = 1'b1;
            end else if (b[7]) begin
                // other status closes the sysex and is parsed as usual
                port_st[p].sysex_on = 1'b0;
                port_st[p].have     = 2'd0;
            end else begin
                if (port_st[p].count < HEAD_LEN) begin
                    port_head[p][port_st[p].count] = b;
                    port_st[p].count = port_st[p].count + 3'd1;
                end
                add_msg(2'd1, b, 8'h00, 8'h00);
                done = 1'b1;
            end
        end
        if (!done) begin
            if (b == ST_SYSEX) begin
                port_st[p].sysex_on = 1'b1;
                port_st[p].count    = 3'd0;
                port_st[p].rstat    = 8'h00;
                add_msg(2'd1, b, 8'h00, 8'h00);
            end else if (b > ST_SYSEX) begin
                // system common passes and kills running status
                port_st[p].rstat = 8'h00;
                add_msg(2'd1, b, 8'h00, 8'h00);
            end else if (b[7]) begin
                port_st[p].rstat = b;
                port_st[p].have  = 2'd0;
                port_st[p].need  = (b[7:4] == KIND_PC[7:4] || b[7:4] == KIND_CP[7:4]) ?
                                   2'd1 : 2'd2;
            end else if (port_st[p].rstat == 8'h00) begin
                ignored = 1'b1;
            end else if (port_st[p].need == 2'd2 && port_st[p].have == 2'd0) begin
                port_st[p].first = b;
                port_st[p].have  = 2'd1;
            end else begin
                if (port_st[p].need == 2'd2) begin
                    d0 = port_st[p].first;
                    d1 = b;
                end else begin
                    d0 = b;
                    d1 = 8'h00;
                end
                port_st[p].have = 2'd0;
                ch = port_st[p].rstat[3:0];
                if (port_st[p].rstat[7:4] == KIND_CC[7:4] && d0 == CC_BANK_LSB) begin
                    d1 = {1'b0, bank_reg};
                    port_st[p].mask[ch] = 1'b1;
                end else if (port_st[p].rstat[7:4] == KIND_PC[7:4] &&
                             !port_st[p].mask[ch]) begin
                    add_bank_select(ch);
                    port_st[p].mask[ch] = 1'b1;
                end
                add_msg((port_st[p].need == 2'd2) ? 2'd3 : 2'd2, port_st[p].rstat, d0, d1);
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        return ignored;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    function automatic void add_row(t_exp chk, logic op, logic [1:0] pnum, logic [7:0] data);
        t_row r;
        r.chk            = chk;
        r.item.op        = op;
        r.item.port      = pnum;
        r.item.data_byte = data;
        dir_rows.push_back(r);
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic feed(t_in it, t_exp chk);
        t_out echo;
        bit   ignored;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ignored = remap_byte(it);
        beats_in++;
        if (!ignored)
            useful++;
        case (chk)
            EXP_MODEL: begin
                foreach (burst[k])
                    pending_msgs.push_back(burst[k]);
            end
            EXP_ECHO: begin
                echo.msg_len = 2'd1;
                echo.byte_a  = it.data_byte;
                echo.byte_b  = 8'h00;
                echo.byte_c  = 8'h00;
                echo.last    = 1'b1;
                pending_msgs.push_back(echo);
            end
            default: ;
        endcase
    endtask

    // hold the sender until every expected beat is back, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write of the bank value, then read it back
    task automatic write_bank(logic [6:0] v);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BANK_ADDR;
        pwdata  <= {25'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        bank_reg = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {25'h0, v}) begin
            $error("prdata mismatch: expected %h, got %h", {25'h0, v}, got);
            fail_count++;
        end
    endtask

    // mostly well-formed messages and sysex on random ports, plus noise
    task automatic random_phase(int target);
        logic [7:0] seq [$];
        t_in        it;
        int         p;
        int         pick;
        int         n;
        int         start;
        bit         held;
        logic [3:0] kind;
        start = useful;
        held  = 1'b0;
        while (useful - start < target) begin
            if (!held && useful - start >= target / 2) begin
                drain();
                held = 1'b1;
            end
            p    = $urandom_range(NPORTS - 1);
            pick = $urandom_range(99);
            seq.delete();
            if (pick < 40) begin
                // channel message, sometimes on running status
                n = $urandom_range(9);
                kind = (n < 3) ? KIND_CC[7:4] : (n < 6) ? KIND_PC[7:4] :
                       4'($urandom_range(8, 14));
                if ($urandom_range(3) != 0)
                    seq.push_back({kind, 4'($urandom_range(15))});
                if (kind == KIND_CC[7:4] && $urandom_range(1) == 1)
                    seq.push_back(CC_BANK_LSB);
                else
                    seq.push_back(8'($urandom_range(127)));
                if (kind != KIND_PC[7:4] && kind != KIND_CP[7:4])
                    seq.push_back(8'($urandom_range(127)));
            end else if (pick < 60) begin
                // reset sysex, sometimes with one byte spoiled
                seq.push_back(ST_SYSEX);
                n = $urandom_range(2);
                if (n == 0) begin
                    seq.push_back(UNIV_NRT);
                    seq.push_back(8'($urandom_range(127)));
                    seq.push_back(GM_SUB);
                    seq.push_back(($urandom_range(1) == 1) ? GM_ON : GM2_ON);
                end else if (n == 1) begin
                    seq.push_back(ID_XG);
                    seq.push_back(8'($urandom_range(16, 31)));
                    seq.push_back(XG_MODEL);
                    seq.push_back(8'h00);
                    seq.push_back(8'h00);
                    seq.push_back(XG_ON);
                    seq.push_back(8'h00);
                end else begin
                    seq.push_back(ID_GS);
                    seq.push_back(8'($urandom_range(127)));
                    seq.push_back(GS_MODEL);
                    seq.push_back(GS_DT1);
                    seq.push_back(($urandom_range(1) == 1) ? GS_ADDR_HI : GS_ADDR_ALT);
                    seq.push_back(8'h00);
                    seq.push_back(GS_ON);
                    seq.push_back(8'h00);
                    seq.push_back(8'($urandom_range(127)));
                end
                if ($urandom_range(3) == 0)
                    seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom_range(127));
                seq.push_back(ST_EOX);
            end else if (pick < 75) begin
                // plain sysex of up to 12 data bytes, ended in several ways
                seq.push_back(ST_SYSEX);
                n = $urandom_range(12);
                repeat (n) seq.push_back(8'($urandom_range(127)));
                n = $urandom_range(9);
                if (n < 6)
                    seq.push_back(ST_EOX);
                else if (n < 8)
                    seq.push_back(8'($urandom_range(128, 239)));
                else if (n == 8)
                    seq.push_back(ST_SYSEX);
                else
                    seq.push_back(8'($urandom_range(241, 246)));
            end else if (pick < 85) begin
                seq.push_back(ST_RT_MIN + 8'($urandom_range(7)));
            end else if (pick < 92) begin
                seq.push_back(8'($urandom_range(241, 247)));
            end else if (pick < 95) begin
                it.op        = OP_PRESET;
                it.port      = 2'(p);
                it.data_byte = 8'($urandom);
                feed(it, EXP_MODEL);
            end else begin
                seq.push_back(8'($urandom));
            end
            foreach (seq[k]) begin
                // now and then a byte for another port lands in the middle
                if ($urandom_range(9) == 0) begin
                    it.op        = OP_FILTER;
                    it.port      = 2'(p + $urandom_range(1, 3));
                    it.data_byte = 8'($urandom);
                    feed(it, EXP_MODEL);
                end
                it.op        = OP_FILTER;
                it.port      = 2'(p);
                it.data_byte = seq[k];
                feed(it, EXP_MODEL);
            end
        end
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out++;
            if (pending_msgs.size() == 0) begin
                $error("result beat with nothing expected: len %0d bytes %h %h %h",
                       o_out.msg_len, o_out.byte_a, o_out.byte_b, o_out.byte_c);
                fail_count++;
            end else begin
                want = pending_msgs.pop_front();
                check_field("msg_len", 8'(want.msg_len), 8'(o_out.msg_len));
                check_field("byte_a", want.byte_a, o_out.byte_a);
                check_field("byte_b", want.byte_b, o_out.byte_b);
                check_field("byte_c", want.byte_c, o_out.byte_c);
                check_field("last", 8'(want.last), 8'(o_out.last));
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        foreach (port_st[k])
            port_st[k] = '0;
        bank_reg = 7'd0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bank at its top value, no flow control
        write_bank(7'h7F);
        add_row(EXP_NONE,  OP_FILTER, 2'd0, 8'h45);     // orphan data after reset
        add_row(EXP_ECHO,  OP_FILTER, 2'd0, ST_RT_MIN);
        add_row(EXP_ECHO,  OP_FILTER, 2'd0, 8'hFF);
        add_row(EXP_NONE,  OP_FILTER, 2'd0, 8'h80);     // status alone yields nothing
        add_row(EXP_MODEL, OP_FILTER, 2'd0, 8'h00);
        add_row(EXP_MODEL, OP_FILTER, 2'd0, 8'h7F);
        add_row(EXP_NONE,  OP_FILTER, 2'd0, 8'hBF);
        add_row(EXP_MODEL, OP_FILTER, 2'd0, CC_BANK_LSB);
        add_row(EXP_MODEL, OP_FILTER, 2'd0, 8'h13);     // bank value replaced
        add_row(EXP_NONE,  OP_FILTER, 2'd0, 8'hC5);
        add_row(EXP_MODEL, OP_FILTER, 2'd0, 8'h00);     // bank select inserted
        add_row(EXP_MODEL, OP_FILTER, 2'd0, 8'h7F);     // running status, already selected
        add_row(EXP_NONE,  OP_FILTER, 2'd1, 8'hD2);
        add_row(EXP_MODEL, OP_FILTER, 2'd1, 8'h7F);
        add_row(EXP_ECHO,  OP_FILTER, 2'd1, 8'hF1);     // system common
        add_row(EXP_NONE,  OP_FILTER, 2'd1, 8'h10);     // running status gone
        add_row(EXP_ECHO,  OP_FILTER, 2'd2, ST_SYSEX);
        add_row(EXP_MODEL, OP_FILTER, 2'd2, UNIV_NRT);
        add_row(EXP_MODEL, OP_FILTER, 2'd2, 8'h7F);
        add_row(EXP_MODEL, OP_FILTER, 2'd2, GM_SUB);
        add_row(EXP_MODEL, OP_FILTER, 2'd2, GM_ON);
        add_row(EXP_MODEL, OP_FILTER, 2'd2, ST_EOX);    // gm reset, preset follows
        add_row(EXP_MODEL, OP_PRESET, 2'd3, 8'hFF);
        add_row(EXP_ECHO,  OP_FILTER, 2'd2, ST_SYSEX);
        add_row(EXP_MODEL, OP_FILTER, 2'd2, ST_SYSEX);  // restart inside sysex
        add_row(EXP_MODEL, OP_FILTER, 2'd2, 8'h93);     // status closes sysex
        foreach (dir_rows[k])
            feed(dir_rows[k].item, dir_rows[k].chk);
        drain();

        // random phases, one flow-control mode each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  write_bank(7'h00); end
                1: begin gap_pct = 65; stall_pct = 0;  write_bank(7'($urandom_range(1, 126))); end
                2: begin gap_pct = 0;  stall_pct = 65; write_bank(7'h7F); end
                default: begin
                    gap_pct   = 18;
                    stall_pct = 18;
                    write_bank(7'($urandom));
                end
            endcase
            random_phase(60);
            drain();
        end

        $display("summary: %0d input beats sent, %0d result beats checked", beats_in, beats_out);
        $display("summary: directed table plus four flow-control phases, bank at both ends");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/mbsr_pkg.sv
rtl/mbsr_seq.sv
rtl/midi_bank_select_remapper_core.sv
verif/midi_bank_select_remapper_core_tb.sv
